@@ src/media_frame_pacing_clock_top_assert.svh @@
// Assertion macros for the media frame pacing clock.
// Used by media_frame_pacing_clock_top; expects signals named clk and rst in scope.
`ifndef MEDIA_FRAME_PACING_CLOCK_TOP_ASSERT_SVH
`define MEDIA_FRAME_PACING_CLOCK_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFPC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mfpc_pkg.sv @@
// Shared types and constants for the media frame pacing clock.
// No dependencies; imported by media_frame_pacing_clock_top.
package mfpc_pkg;

  localparam int TIME_W     = 48;
  localparam int POS_W      = 47;
  localparam int DUR_W      = 40;
  localparam int FI_W       = 32;
  localparam int USER_W     = 16;
  localparam int ALU_W      = TIME_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DUR_W;

  localparam logic [FI_W-1:0]   FI_DEFAULT = FI_W'(33333);
  localparam int                SUSPEND_US_DEFAULT = 250000;
  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [USER_W-1:0] USER_MAX = {USER_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_DURATION       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTERVAL = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ACT_ADD_USER,
    ACT_DROP_USER,
    ACT_HOST_PAUSE,
    ACT_HOST_VISIBLE,
    ACT_MANUAL_PAUSE,
    ACT_SEEK,
    ACT_SAMPLE,
    ACT_DECODED
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_ADD,
    ST_DIV,
    ST_EVAL_A,
    ST_EVAL_B,
    ST_REPORT
  } state_t;

  typedef struct packed {
    action_t                  action;
    logic                     flag_value;
    logic signed [TIME_W-1:0] time_value;
    logic                     time_invalid;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  position_us;
    logic              should_decode;
    logic              wrapped;
    logic              is_active;
    logic [USER_W-1:0] user_count;
  } out_t;

endpackage

@@ src/media_frame_pacing_clock_top.sv @@
// Looping playback-position clock with a shared add/subtract unit and a restoring modulo.
// User, flag, decode-report, inactive or invalid sample and zero-duration seek transactions
// go straight to report; an unanchored sample runs the evaluation steps; an anchored
// sample computes and adds the elapsed time, runs the modulo if the duration is nonzero,
// then evaluates; a seek with nonzero duration runs only the modulo. The modulo handles one
// dividend bit (48) per cycle on the shared subtractor. One transaction is in work at a
// time: the next is accepted once the result enters the output register, which may wait.
// Reset is synchronous; it clears control and playback state and sets the frame interval to 33333 us.
module media_frame_pacing_clock_top #(
  parameter int SUSPEND_US = mfpc_pkg::SUSPEND_US_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mfpc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mfpc_pkg::out_t                  out_data,
  input  logic                            cfg_write,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mfpc_pkg::*;

  localparam int ELAPSED_W = $clog2(SUSPEND_US + 1);
  localparam int DIV_STEPS = TIME_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  state_t state, state_next;

  logic [DUR_W-1:0]  duration;
  logic [FI_W-1:0]   frame_interval;
  logic [POS_W-1:0]  position;
  logic [TIME_W-1:0] anchor_time;
  logic              anchor_valid;
  logic [POS_W-1:0]  decoded_position;
  logic              decoded_valid;
  logic [USER_W-1:0] users;
  logic              host_paused;
  logic              host_visible;
  logic              manual_paused;

  action_t           act;
  logic [TIME_W-1:0] time_in;
  logic [ELAPSED_W-1:0] elapsed;
  logic [TIME_W-1:0] work;
  logic [DUR_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              folded;
  logic              behind;
  logic              rep_decode;
  logic              rep_wrapped;

  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic              alu_sub;
  logic [ALU_W-1:0]  alu_res;
  logic [DUR_W-1:0]  rem_step;
  logic              active;
  logic [FI_W-1:0]   interval;
  logic              report_go;
  logic              wrap_now;
  logic [POS_W-1:0]  clamp_in;

  assign active   = (users != '0) && !host_paused && host_visible && !manual_paused;
  assign interval = (frame_interval == '0) ? FI_DEFAULT : frame_interval;
  assign in_ready = (state == ST_IDLE);
  assign report_go = (state == ST_REPORT) && (!out_valid || out_ready);
  assign alu_res  = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign rem_step = !alu_res[ALU_W-1] ? alu_res[DUR_W-1:0] : {rem[DUR_W-2:0], work[TIME_W-1]};
  assign wrap_now = folded || (decoded_valid && behind);
  assign clamp_in = in_data.time_value[TIME_W-1] ? '0 : in_data.time_value[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.action)
            ACT_SEEK: begin
              state_next = (duration != '0) ? ST_DIV : ST_REPORT;
            end
            ACT_SAMPLE: begin
              if (!active || in_data.time_invalid) begin
                state_next = ST_REPORT;
              end else if (anchor_valid) begin
                state_next = ST_ELAPSED;
              end else begin
                state_next = ST_EVAL_A;
              end
            end
            default: begin
              state_next = ST_REPORT;
            end
          endcase
        end
      end
      ST_ELAPSED: begin
        alu_a      = {time_in[TIME_W-1], time_in};
        alu_b      = {anchor_time[TIME_W-1], anchor_time};
        alu_sub    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        alu_a      = ALU_W'(position);
        alu_b      = ALU_W'(elapsed);
        state_next = (duration == '0) ? ST_EVAL_A : ST_DIV;
      end
      ST_DIV: begin
        alu_a   = ALU_W'({rem, work[TIME_W-1]});
        alu_b   = ALU_W'(duration);
        alu_sub = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = (act == ACT_SEEK) ? ST_REPORT : ST_EVAL_A;
        end
      end
      ST_EVAL_A: begin
        alu_a      = ALU_W'(position);
        alu_b      = ALU_W'(decoded_position);
        alu_sub    = 1'b1;
        state_next = ST_EVAL_B;
      end
      ST_EVAL_B: begin
        alu_a      = ALU_W'(behind ? decoded_position : position);
        alu_b      = ALU_W'(behind ? position : decoded_position);
        alu_sub    = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration       <= '0;
      frame_interval <= FI_DEFAULT;
    end else if (cfg_write) begin
      if (cfg_index == REG_DURATION) begin
        duration <= cfg_data[DUR_W-1:0];
      end else if (cfg_index == REG_FRAME_INTERVAL) begin
        frame_interval <= cfg_data[FI_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      anchor_time      <= '0;
      anchor_valid     <= 1'b0;
      decoded_position <= '0;
      decoded_valid    <= 1'b0;
      users            <= '0;
      host_paused      <= 1'b0;
      host_visible     <= 1'b1;
      manual_paused    <= 1'b0;
      act              <= ACT_ADD_USER;
      cnt              <= '0;
      folded           <= 1'b0;
      behind           <= 1'b0;
      rep_decode       <= 1'b0;
      rep_wrapped      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            act         <= in_data.action;
            time_in     <= in_data.time_value;
            rep_decode  <= 1'b0;
            rep_wrapped <= 1'b0;
            folded      <= 1'b0;
            cnt         <= '0;
            rem         <= '0;
            case (in_data.action)
              ACT_ADD_USER: begin
                if (users != USER_MAX) begin
                  users <= users + USER_W'(1);
                end
                anchor_valid <= 1'b0;
              end
              ACT_DROP_USER: begin
                if (users != '0) begin
                  users <= users - USER_W'(1);
                end
                anchor_valid <= 1'b0;
              end
              ACT_HOST_PAUSE: begin
                if (host_paused != in_data.flag_value) begin
                  host_paused  <= in_data.flag_value;
                  anchor_valid <= 1'b0;
                end
              end
              ACT_HOST_VISIBLE: begin
                if (host_visible != in_data.flag_value) begin
                  host_visible <= in_data.flag_value;
                  anchor_valid <= 1'b0;
                end
              end
              ACT_MANUAL_PAUSE: begin
                if (manual_paused != in_data.flag_value) begin
                  manual_paused <= in_data.flag_value;
                  anchor_valid  <= 1'b0;
                end
              end
              ACT_SEEK: begin
                decoded_valid <= 1'b0;
                anchor_valid  <= 1'b0;
                if (duration == '0) begin
                  position <= '0;
                end
                work <= in_data.time_invalid ? '0 : TIME_W'(clamp_in);
              end
              ACT_SAMPLE: begin
                if (!active || in_data.time_invalid) begin
                  anchor_valid <= 1'b0;
                end else if (!anchor_valid) begin
                  anchor_time  <= in_data.time_value;
                  anchor_valid <= 1'b1;
                end
              end
              default: begin
                if (!in_data.time_invalid) begin
                  decoded_position <= clamp_in;
                  decoded_valid    <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_ELAPSED: begin
          anchor_time <= time_in;
          if (!alu_res[ALU_W-1] && alu_res != '0 && alu_res <= ALU_W'(SUSPEND_US)) begin
            elapsed <= alu_res[ELAPSED_W-1:0];
          end else begin
            elapsed <= '0;
          end
        end
        ST_ADD: begin
          if (duration == '0) begin
            position <= alu_res[POS_W] ? POS_MAX : alu_res[POS_W-1:0];
          end else begin
            work <= alu_res[TIME_W-1:0];
          end
        end
        ST_DIV: begin
          work <= {work[TIME_W-2:0], 1'b0};
          rem  <= rem_step;
          cnt  <= cnt + CNT_W'(1);
          if (!alu_res[ALU_W-1]) begin
            folded <= 1'b1;
          end
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            position <= POS_W'(rem_step);
          end
        end
        ST_EVAL_A: begin
          behind <= alu_res[ALU_W-1];
        end
        ST_EVAL_B: begin
          rep_wrapped <= wrap_now;
          rep_decode  <= wrap_now || !decoded_valid ||
                         (alu_res[POS_W-1:0] >= POS_W'(interval));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_go) begin
      out_data.position_us   <= position;
      out_data.should_decode <= rep_decode;
      out_data.wrapped       <= rep_wrapped;
      out_data.is_active     <= active;
      out_data.user_count    <= users;
    end
  end

`include "media_frame_pacing_clock_top_assert.svh"

  `MFPC_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state != ST_IDLE, "busy after accept")
  `MFPC_ASSERT_SAME(a_div_count, state == ST_DIV, cnt <= CNT_W'(DIV_STEPS - 1), "modulo overrun")
  `MFPC_ASSERT_SAME(a_wrap_decode, out_valid && out_data.wrapped, out_data.should_decode,
                    "wrap without decode")
  `MFPC_ASSERT_SAME(a_decode_active, out_valid && out_data.should_decode, out_data.is_active,
                    "decode while inactive")

endmodule

@@ dv/mfpc_tb_pkg.sv @@
// Scoreboard for the media frame pacing clock testbench: predicts each result from
// the accepted input transactions and checks what the block returns.
// Depends on mfpc_pkg for the transaction types and register indexes.
`timescale 1ns / 1ps

package mfpc_tb_pkg;
  import mfpc_pkg::*;

  class pacing_scoreboard;
    logic [DUR_W-1:0]         loop_len;
    logic [FI_W-1:0]          min_step;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         decoded_pos;
    logic signed [TIME_W-1:0] anchor;
    bit                       anchor_ok;
    bit                       decoded_ok;
    bit                       host_paused;
    bit                       host_visible;
    bit                       manual_paused;
    logic [USER_W-1:0]        users;
    out_t                     expected_results[$];
    int                       mismatches;

    function new();
      loop_len = '0;
      min_step = FI_DEFAULT;
      position = '0;
      decoded_pos = '0;
      anchor = '0;
      anchor_ok = 1'b0;
      decoded_ok = 1'b0;
      host_paused = 1'b0;
      host_visible = 1'b1;
      manual_paused = 1'b0;
      users = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
      if (idx == REG_DURATION) begin
        loop_len = word[DUR_W-1:0];
      end else if (idx == REG_FRAME_INTERVAL) begin
        min_step = word[FI_W-1:0];
      end
    endfunction

    function bit running();
      return users != 0 && !host_paused && host_visible && !manual_paused;
    endfunction

    function logic [POS_W-1:0] clamp_at_zero(logic signed [TIME_W-1:0] value);
      if (value < 0) return '0;
      return value[POS_W-1:0];
    endfunction

    function out_t step_clock(in_t item);
      out_t             res;
      longint           elapsed;
      longint unsigned  sum;
      longint unsigned  interval;
      longint unsigned  diff;
      logic [POS_W-1:0] target;
      bit               folded;
      res = '0;
      folded = 1'b0;
      case (item.action)
        ACT_ADD_USER: begin
          if (users != USER_MAX) users = users + 1'b1;
          anchor_ok = 1'b0;
        end
        ACT_DROP_USER: begin
          if (users != 0) users = users - 1'b1;
          anchor_ok = 1'b0;
        end
        ACT_HOST_PAUSE: begin
          if (host_paused != item.flag_value) begin
            host_paused = item.flag_value;
            anchor_ok = 1'b0;
          end
        end
        ACT_HOST_VISIBLE: begin
          if (host_visible != item.flag_value) begin
            host_visible = item.flag_value;
            anchor_ok = 1'b0;
          end
        end
        ACT_MANUAL_PAUSE: begin
          if (manual_paused != item.flag_value) begin
            manual_paused = item.flag_value;
            anchor_ok = 1'b0;
          end
        end
        ACT_SEEK: begin
          target = item.time_invalid ? '0 : clamp_at_zero(item.time_value);
          position = (loop_len != 0) ? POS_W'(64'(target) % 64'(loop_len)) : '0;
          decoded_ok = 1'b0;
          anchor_ok = 1'b0;
        end
        ACT_SAMPLE: begin
          if (!running() || item.time_invalid) begin
            anchor_ok = 1'b0;
          end else begin
            if (anchor_ok) begin
              if (item.time_value > anchor) begin
                elapsed = longint'(item.time_value) - longint'(anchor);
              end else begin
                elapsed = 0;
              end
              sum = 64'(position);
              if (elapsed <= SUSPEND_US_DEFAULT) begin
                sum = sum + 64'(elapsed);
                if (loop_len == 0 && sum > 64'(POS_MAX)) sum = 64'(POS_MAX);
              end
              if (loop_len != 0 && sum >= 64'(loop_len)) begin
                sum = sum % 64'(loop_len);
                folded = 1'b1;
              end
              position = POS_W'(sum);
            end
            anchor = item.time_value;
            anchor_ok = 1'b1;
            res.wrapped = folded || (decoded_ok && position < decoded_pos);
            interval = (min_step != 0) ? 64'(min_step) : 64'(FI_DEFAULT);
            diff = (position >= decoded_pos) ? 64'(position - decoded_pos)
                                             : 64'(decoded_pos - position);
            res.should_decode = res.wrapped || !decoded_ok || diff >= interval;
          end
        end
        default: begin
          if (!item.time_invalid) begin
            decoded_pos = clamp_at_zero(item.time_value);
            decoded_ok = 1'b1;
          end
        end
      endcase
      res.position_us = position;
      res.is_active = running();
      res.user_count = users;
      return res;
    endfunction

    function void note_input(in_t item);
      expected_results.push_back(step_clock(item));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result transaction at %0t: pos %0d users %0d",
                   $time, got.position_us, got.user_count);
        end
        return;
      end
      want = expected_results.pop_front();
      if (got.position_us !== want.position_us || got.should_decode !== want.should_decode ||
          got.wrapped !== want.wrapped || got.is_active !== want.is_active ||
          got.user_count !== want.user_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result mismatch at %0t: expected pos %0d dec %0b wrap %0b act %0b users %0d",
                   $time, want.position_us, want.should_decode, want.wrapped,
                   want.is_active, want.user_count);
          $display("  actual pos %0d dec %0b wrap %0b act %0b users %0d",
                   got.position_us, got.should_decode, got.wrapped, got.is_active,
                   got.user_count);
        end
      end
    endfunction
  endclass

endpackage

@@ dv/tb_media_frame_pacing_clock_top.sv @@
// Testbench top for media_frame_pacing_clock_top: directed and random transactions,
// register settings per phase, random idling on both channels and a final verdict.
// Depends on mfpc_pkg and on the scoreboard class in mfpc_tb_pkg.
`timescale 1ns / 1ps

module tb_media_frame_pacing_clock_top;
  import mfpc_pkg::*;
  import mfpc_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam longint TIME_MAX = (64'sd1 <<< 47) - 1;
  localparam longint TIME_MIN = -(64'sd1 <<< 47);
  localparam longint unsigned DUR_FULL = (64'd1 << DUR_W) - 1;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 170;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pacing_scoreboard sb;
  int unsigned      tx_idle_pct = 27;
  int unsigned      rx_idle_pct = 65;
  bit               rx_hold_req = 1'b0;
  bit               rx_hold_done = 1'b0;
  longint           mono = 64'sd5_000_000;
  longint unsigned  cur_duration = 0;

  media_frame_pacing_clock_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_t make_item(action_t act, logic flag, longint value, logic bad);
    in_t item;
    item.action = act;
    item.flag_value = flag;
    item.time_value = value[TIME_W-1:0];
    item.time_invalid = bad;
    return item;
  endfunction

  function automatic longint pick_position(int unsigned roll, logic [63:0] raw);
    longint unsigned span;
    span = (cur_duration != 0) ? 2 * cur_duration : 64'd1 << 22;
    if (roll < 70) return longint'(raw % span);
    if (roll < 85) return -longint'(raw[19:0]) - 1;
    return longint'(raw);
  endfunction

  function automatic in_t next_item();
    int unsigned pick;
    int unsigned roll;
    logic [63:0] raw;
    longint      step;
    in_t         item;
    pick = $urandom_range(99);
    roll = $urandom_range(99);
    raw = {$urandom, $urandom};
    item = make_item(ACT_SAMPLE, raw[63], mono, $urandom_range(99) < 3);
    if (pick < 5) begin
      item = in_t'(raw[$bits(in_t)-1:0]);
    end else if (pick < 13) begin
      item.action = ACT_ADD_USER;
    end else if (pick < 18) begin
      item.action = ACT_DROP_USER;
    end else if (pick < 22) begin
      item.action = ACT_HOST_PAUSE;
      item.flag_value = (roll < 25);
    end else if (pick < 25) begin
      item.action = ACT_HOST_VISIBLE;
      item.flag_value = (roll < 85);
    end else if (pick < 29) begin
      item.action = ACT_MANUAL_PAUSE;
      item.flag_value = (roll < 25);
    end else if (pick < 36) begin
      item.action = ACT_SEEK;
      item.time_value = TIME_W'(pick_position(roll, raw));
    end else if (pick < 46) begin
      item.action = ACT_DECODED;
      item.time_value = TIME_W'(pick_position(roll, raw));
    end else begin
      if (roll < 70) step = $urandom_range(1, 60000);
      else if (roll < 80) step = $urandom_range(SUSPEND_US_DEFAULT + 1, 2_000_000);
      else if (roll < 84) step = SUSPEND_US_DEFAULT + roll % 2;
      else if (roll < 92) step = -longint'($urandom_range(1, 50000));
      else step = 0;
      mono += step;
      item.time_value = mono[TIME_W-1:0];
    end
    return item;
  endfunction

  task automatic send_item(in_t item);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  task automatic sample_at(longint delta);
    mono += delta;
    send_item(make_item(ACT_SAMPLE, 1'b0, mono, 1'b0));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic configure(longint unsigned dur, longint unsigned interval);
    logic [CFG_DATA_W-1:0] word;
    wait_drained();
    word = dur[CFG_DATA_W-1:0];
    cfg_write <= 1'b1;
    cfg_index <= REG_DURATION;
    cfg_data <= word;
    @(posedge clk);
    sb.write_reg(REG_DURATION, word);
    word = {8'($urandom), interval[FI_W-1:0]};
    cfg_index <= REG_FRAME_INTERVAL;
    cfg_data <= word;
    @(posedge clk);
    sb.write_reg(REG_FRAME_INTERVAL, word);
    word = {$urandom, $urandom};
    cfg_index <= REG_SPARE;
    cfg_data <= word;
    @(posedge clk);
    sb.write_reg(REG_SPARE, word);
    cfg_write <= 1'b0;
    cur_duration = dur;
  endtask

  initial begin
    longint unsigned loop_lens[6];
    longint unsigned intervals[6];
    loop_lens = '{1_000_000, 100_000, 0, DUR_FULL, 1, 250_000};
    intervals = '{33333, 1, 64'hFFFF_FFFF, 0, 16667, 33333};
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(1_000_000, 33333);
    sample_at(0);
    send_item(make_item(ACT_DROP_USER, 1'b0, 0, 1'b0));
    send_item(make_item(ACT_ADD_USER, 1'b1, -1, 1'b1));
    sample_at(0);
    sample_at(20_000);
    send_item(make_item(ACT_DECODED, 1'b0, 20_000, 1'b0));
    sample_at(10_000);
    sample_at(-20_000);
    sample_at(SUSPEND_US_DEFAULT);
    sample_at(SUSPEND_US_DEFAULT + 1);
    send_item(make_item(ACT_DECODED, 1'b0, -5, 1'b1));
    send_item(make_item(ACT_DECODED, 1'b0, -1, 1'b0));
    send_item(make_item(ACT_DECODED, 1'b0, TIME_MAX, 1'b0));
    sample_at(10);
    send_item(make_item(ACT_SEEK, 1'b0, TIME_MIN, 1'b0));
    send_item(make_item(ACT_SEEK, 1'b0, 12_345, 1'b1));
    send_item(make_item(ACT_SEEK, 1'b1, TIME_MAX, 1'b0));
    send_item(make_item(ACT_SEEK, 1'b0, 999_990, 1'b0));
    sample_at(0);
    sample_at(50);
    send_item(make_item(ACT_HOST_PAUSE, 1'b1, 0, 1'b0));
    send_item(make_item(ACT_HOST_PAUSE, 1'b1, 0, 1'b0));
    send_item(make_item(ACT_HOST_PAUSE, 1'b0, 0, 1'b0));
    send_item(make_item(ACT_HOST_VISIBLE, 1'b0, 0, 1'b0));
    send_item(make_item(ACT_HOST_VISIBLE, 1'b1, 0, 1'b0));
    send_item(make_item(ACT_MANUAL_PAUSE, 1'b1, 0, 1'b0));
    send_item(make_item(ACT_MANUAL_PAUSE, 1'b0, 0, 1'b0));
    send_item(make_item(ACT_SAMPLE, 1'b1, mono, 1'b1));

    // A position left beyond a shortened loop must fold on the next anchored sample.
    configure(DUR_FULL, 33333);
    send_item(make_item(ACT_SEEK, 1'b0, 64'sd1_099_511_627_000, 1'b0));
    sample_at(0);
    sample_at(100);
    configure(5_000, 33333);
    sample_at(200);

    for (int p = 0; p < 6; p++) begin
      configure(loop_lens[p], intervals[p]);
      tx_idle_pct = (p < 2) ? 27 : (p < 4) ? 65 : 0;
      rx_idle_pct = (p < 2) ? 65 : (p < 4) ? 27 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 20) rx_hold_req = 1'b1;
        if (p == 3 && n == 80) wait_drained();
        send_item(next_item());
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
